FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the SM3 engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// Types, constants and helper functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

    typedef logic [31:0] word_t;
    typedef logic [0:7][31:0] regs_t;
    typedef logic [0:15][31:0] window_t;

    localparam word_t T_EARLY = 32'h79cc4519;
    localparam word_t T_LATE  = 32'h7a879d8a;
    localparam word_t PAD_MARKER = 32'h80000000;

    localparam regs_t SM3_IV = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } state_t;

    // Padding phases
    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN_LO
    } pad_phase_t;

    // Control from the sequencer to the compression unit
    typedef struct packed {
        logic  push;
        logic  start;
        word_t word;
    } comp_ctl_t;

    // Status from the compression unit
    typedef struct packed {
        logic busy;
        logic done;
    } comp_status_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

FILE: hw/rtl/sm3_if.sv
// ----------------------------------------------------------------------------
// sm3_if
// Valid/ready channels of the SM3 engine: message words in, digest words out.
// ----------------------------------------------------------------------------
interface sm3_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  bytes_valid;
    logic        last_word;

    modport source (output valid, output data_word, output bytes_valid,
                    output last_word, input ready);
    modport sink   (input valid, input data_word, input bytes_valid,
                    input last_word, output ready);
endinterface

interface sm3_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_run;

    modport source (output valid, output digest_word, output word_index,
                    output last_of_run, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/sm3_round.sv
// ----------------------------------------------------------------------------
// sm3_round
// One SM3 compression round plus one message expansion step.
// ----------------------------------------------------------------------------
module sm3_round (
    input  sm3_pkg::regs_t   regs,
    input  sm3_pkg::window_t window,
    input  logic [5:0]       rnd,
    output sm3_pkg::regs_t   regs_new,
    output sm3_pkg::word_t   w_new
);

    logic           early;
    sm3_pkg::word_t t_rot;
    sm3_pkg::word_t a12;
    sm3_pkg::word_t ss1;
    sm3_pkg::word_t ss2;
    sm3_pkg::word_t ff;
    sm3_pkg::word_t gg;
    sm3_pkg::word_t tt1;
    sm3_pkg::word_t tt2;
    sm3_pkg::word_t w0;
    sm3_pkg::word_t w4;
    sm3_pkg::word_t x;

    assign early = (rnd[5:4] == 2'b00);
    assign w0    = window[0];
    assign w4    = window[4];

    always_comb
    begin
        t_rot = sm3_pkg::rotl(early ? sm3_pkg::T_EARLY : sm3_pkg::T_LATE, rnd[4:0]);
        a12   = sm3_pkg::rotl(regs[0], 5'd12);
        ss1   = sm3_pkg::rotl(a12 + regs[4] + t_rot, 5'd7);
        ss2   = ss1 ^ a12;
        if (early)
        begin
            ff = regs[0] ^ regs[1] ^ regs[2];
            gg = regs[4] ^ regs[5] ^ regs[6];
        end
        else
        begin
            ff = (regs[0] & regs[1]) | (regs[0] & regs[2]) | (regs[1] & regs[2]);
            gg = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
        end
        tt1 = ff + regs[3] + ss2 + (w0 ^ w4);
        tt2 = gg + regs[7] + ss1 + w0;

        regs_new[0] = tt1;
        regs_new[1] = regs[0];
        regs_new[2] = sm3_pkg::rotl(regs[1], 5'd9);
        regs_new[3] = regs[2];
        regs_new[4] = sm3_pkg::perm0(tt2);
        regs_new[5] = regs[4];
        regs_new[6] = sm3_pkg::rotl(regs[5], 5'd19);
        regs_new[7] = regs[6];
    end

    // Window holds W[j..j+15]; produce W[j+16]
    always_comb
    begin
        x     = window[0] ^ window[7] ^ sm3_pkg::rotl(window[13], 5'd15);
        w_new = sm3_pkg::perm1(x) ^ sm3_pkg::rotl(window[3], 5'd7) ^ window[10];
    end

endmodule

FILE: hw/rtl/sm3_compress.sv
// ----------------------------------------------------------------------------
// sm3_compress
// Block buffer / expansion window and working registers, stepped through
// 64 rounds by a round counter around the shared round unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm3_compress (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sm3_pkg::comp_ctl_t    ctl,
    input  sm3_pkg::regs_t        chain,
    output sm3_pkg::regs_t        result,
    output sm3_pkg::comp_status_t status
);

    sm3_pkg::window_t win_reg;
    sm3_pkg::window_t win_next;
    sm3_pkg::regs_t   r_reg;
    sm3_pkg::regs_t   r_next;
    sm3_pkg::regs_t   round_regs;
    sm3_pkg::word_t   w_new;
    logic [5:0]       rnd_reg;
    logic [5:0]       rnd_next;
    logic             run_reg;
    logic             run_next;
    logic             done_reg;
    logic             done_next;

    sm3_round u_round (
        .regs     (r_reg),
        .window   (win_reg),
        .rnd      (rnd_reg),
        .regs_new (round_regs),
        .w_new    (w_new)
    );

    always_comb
    begin
        win_next  = win_reg;
        r_next    = r_reg;
        rnd_next  = rnd_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        // Message words shift in at the tail; the block ends up in order
        if (ctl.push)
        begin
            win_next = {win_reg[1:15], ctl.word};
        end
        if (ctl.start)
        begin
            r_next   = chain;
            rnd_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            win_next = {win_reg[1:15], w_new};
            r_next   = round_regs;
            rnd_next = rnd_reg + 6'd1;
            if (rnd_reg == 6'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        r_reg   <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rnd_reg  <= rnd_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign result      = r_reg;
    assign status.busy = run_reg;
    assign status.done = done_reg;

    `ASSERT_ALWAYS(a_push_when_stopped, clk, rst_n, ctl.push |-> !run_reg)
    `ASSERT_ALWAYS(a_done_after_last, clk, rst_n, run_reg && rnd_reg == 6'd63 |=> done_reg)
    `ASSERT_ALWAYS(a_done_wrapped, clk, rst_n, done_reg |-> !run_reg && rnd_reg == 6'd0)

endmodule

FILE: hw/rtl/sm3_hash_engine.sv
// ----------------------------------------------------------------------------
// sm3_hash_engine: SM3 hash with internal padding, one round per cycle.
// A word that completes a block starts a compression: 64 rounds of the single
// round unit, then the chain update; no new word is taken until it ends.
// Last word: up to 18 padding pushes, one or two compressions, then 8 outputs.
// Reset loads the IV and clears counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm3_hash_engine (
    input  logic             clk,
    input  logic             rst_n,
    sm3_msg_if.sink          message,
    sm3_dig_if.source        digest
);

    sm3_pkg::state_t       state_reg;
    sm3_pkg::state_t       state_next;
    sm3_pkg::state_t       ret_reg;
    sm3_pkg::state_t       ret_next;
    sm3_pkg::pad_phase_t   phase_reg;
    sm3_pkg::pad_phase_t   phase_next;
    logic [3:0]            count_reg;
    logic [3:0]            count_next;
    logic [63:0]           len_reg;
    logic [63:0]           len_next;
    logic [2:0]            idx_reg;
    logic [2:0]            idx_next;
    sm3_pkg::regs_t        chain_reg;
    sm3_pkg::regs_t        chain_next;

    sm3_pkg::comp_ctl_t    ctl;
    sm3_pkg::comp_status_t cst;
    sm3_pkg::regs_t        comp_result;

    logic [2:0]            nb_clamped;
    sm3_pkg::word_t        keep_mask;
    sm3_pkg::word_t        marker;
    sm3_pkg::word_t        in_word;
    logic [63:0]           len_add;
    logic                  push;
    sm3_pkg::word_t        push_word;
    sm3_pkg::state_t       after;

    sm3_compress u_compress (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .chain  (chain_reg),
        .result (comp_result),
        .status (cst)
    );

    // Input word formatting and padding word selection
    always_comb
    begin
        nb_clamped = (message.bytes_valid > 3'd4) ? 3'd4 : message.bytes_valid;
        case (nb_clamped)
            3'd0:    begin keep_mask = 32'h00000000; marker = 32'h80000000; end
            3'd1:    begin keep_mask = 32'hff000000; marker = 32'h00800000; end
            3'd2:    begin keep_mask = 32'hffff0000; marker = 32'h00008000; end
            3'd3:    begin keep_mask = 32'hffffff00; marker = 32'h00000080; end
            default: begin keep_mask = 32'hffffffff; marker = 32'h00000000; end
        endcase
        if (message.last_word)
        begin
            in_word = (message.data_word & keep_mask) | marker;
            len_add = {58'd0, nb_clamped, 3'b000};
        end
        else
        begin
            in_word = message.data_word;
            len_add = 64'd32;
        end

        push      = 1'b0;
        push_word = '0;
        after     = state_reg;
        case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                push      = message.valid;
                push_word = in_word;
                after     = message.last_word ? sm3_pkg::ST_PAD : sm3_pkg::ST_IDLE;
            end
            sm3_pkg::ST_PAD:
            begin
                push  = 1'b1;
                after = sm3_pkg::ST_PAD;
                case (phase_reg)
                    sm3_pkg::PAD_MARK:
                    begin
                        push_word = sm3_pkg::PAD_MARKER;
                    end
                    sm3_pkg::PAD_ZERO:
                    begin
                        push_word = (count_reg == 4'd14) ? len_reg[63:32] : '0;
                    end
                    default:
                    begin
                        push_word = len_reg[31:0];
                        after     = sm3_pkg::ST_OUT;
                    end
                endcase
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        chain_next = chain_reg;
        case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                if (message.valid)
                begin
                    len_next   = len_reg + len_add;
                    phase_next = (nb_clamped == 3'd4) ? sm3_pkg::PAD_MARK
                                                      : sm3_pkg::PAD_ZERO;
                end
            end
            sm3_pkg::ST_PAD:
            begin
                case (phase_reg)
                    sm3_pkg::PAD_MARK:
                    begin
                        phase_next = sm3_pkg::PAD_ZERO;
                    end
                    sm3_pkg::PAD_ZERO:
                    begin
                        if (count_reg == 4'd14)
                        begin
                            phase_next = sm3_pkg::PAD_LEN_LO;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            sm3_pkg::ST_COMP:
            begin
                if (cst.done)
                begin
                    state_next = ret_reg;
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_next[i] = chain_reg[i] ^ comp_result[i];
                    end
                end
            end
            default:
            begin
                if (digest.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        // Drop the finished message, start over from the IV
                        state_next = sm3_pkg::ST_IDLE;
                        chain_next = sm3_pkg::SM3_IV;
                        len_next   = '0;
                        count_next = '0;
                    end
                end
            end
        endcase
        if (push)
        begin
            count_next = count_reg + 4'd1;
            if (count_reg == 4'd15)
            begin
                state_next = sm3_pkg::ST_COMP;
                ret_next   = after;
            end
            else
            begin
                state_next = after;
            end
        end
    end

    // Outputs
    always_comb
    begin
        message.ready      = (state_reg == sm3_pkg::ST_IDLE);
        digest.valid       = (state_reg == sm3_pkg::ST_OUT);
        digest.digest_word = chain_reg[idx_reg];
        digest.word_index  = idx_reg;
        digest.last_of_run = (idx_reg == 3'd7);
        ctl.push           = push;
        ctl.start          = push && (count_reg == 4'd15);
        ctl.word           = push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm3_pkg::ST_IDLE;
            ret_reg   <= sm3_pkg::ST_IDLE;
            phase_reg <= sm3_pkg::PAD_MARK;
            count_reg <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            chain_reg <= sm3_pkg::SM3_IV;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    `ASSERT_NEVER(a_no_overlap, clk, rst_n, message.ready && digest.valid)
    `ASSERT_ALWAYS(a_done_in_comp, clk, rst_n, cst.done |-> state_reg == sm3_pkg::ST_COMP)
    `ASSERT_ALWAYS(a_start_when_free, clk, rst_n, ctl.start |-> !cst.busy)

endmodule
